/* hw/rtl/bmft_pkg.sv */
package bmft_pkg;

	localparam int PAGES_PER_BLK = 32;
	localparam int PHYS_BLOCKS   = 16;
	localparam int LOG_BLOCKS    = PHYS_BLOCKS - 1;
	localparam int NUM_PAGES     = PHYS_BLOCKS * PAGES_PER_BLK;
	localparam int NUM_SECTORS   = LOG_BLOCKS * PAGES_PER_BLK;
	localparam int PG_W          = $clog2(PAGES_PER_BLK);
	localparam int PB_W          = $clog2(PHYS_BLOCKS);
	localparam int LB_W          = $clog2(LOG_BLOCKS);
	localparam int ADDR_W        = PB_W + PG_W;
	localparam int SEC_W         = 9;
	localparam int DATA_W        = 32;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [SEC_W-1:0]  sector;
		logic [DATA_W-1:0] wdata;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic [1:0]        status;
	} rsp_t;

endpackage

/* hw/rtl/block_mapped_flash_translation_core.sv */
// Block-mapped flash translation core over an internal store of 16 blocks of 32 pages, each page
// holding a written flag, a 9-bit sector tag and a 32-bit word. A read beat returns the word of
// the page tagged with the sector in its mapped block, or all ones with status "absent". A write
// beat into an unmapped logical block claims the lowest free physical block (not the spare) and
// fills page 0; a write of a new sector takes the first unwritten page; a rewrite copies the
// block page by page into the spare, places the new word at the same index, erases the old block
// and makes it the spare. One beat is handled at a time through one read and one write port of the
// page store and a single tag comparator stepped by a small sequencer: a read or append costs one
// scan of the block, allocation a scan of the map, and a rewrite a scan plus a copy pass plus an
// erase pass. After reset the block marks every page unwritten and holds off requests meanwhile.
// Result beats are held in an output register; the next request is taken once the result has been
// collected.
module block_mapped_flash_translation_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bmft_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output bmft_pkg::rsp_t  out_data
);
	import bmft_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CMP, S_ALLOC, S_COPY_RD, S_COPY_WR,
		S_ERASE, S_RESP
	} state_t;

	state_t state_q;
	req_t   req_q;

	// Page store: written flag, tag and word per page, all in memory with one read and one write port.
	logic                   flag_mem [NUM_PAGES];
	logic [SEC_W-1:0]       tag_mem  [NUM_PAGES];
	logic [DATA_W-1:0]      data_mem [NUM_PAGES];
	logic                   flag_rd_q;
	logic [SEC_W-1:0]       tag_rd_q;
	logic [DATA_W-1:0]      data_rd_q;

	logic [LOG_BLOCKS-1:0]  map_valid_q;
	logic [PB_W-1:0]        map_pbn_q [LOG_BLOCKS];
	logic [PB_W-1:0]        spare_q;

	logic [PG_W-1:0]        idx_q;       // page index within the block
	logic [ADDR_W-1:0]      clr_q;       // page under clearing after reset
	logic [PB_W:0]          cand_q;      // candidate physical block in allocation
	logic [LB_W:0]          mk_q;        // map entry under test in allocation
	logic                   used_q;
	logic [PB_W-1:0]        old_q;
	logic [PG_W-1:0]        hit_q;
	logic                   hit_found_q;
	logic [PG_W-1:0]        free_q;
	logic                   free_found_q;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic                   wr_flag;
	logic [SEC_W-1:0]       wr_tag;
	logic [DATA_W-1:0]      wr_word;
	logic [ADDR_W-1:0]      rd_addr;
	logic [LB_W-1:0]        lbn;
	logic                   in_range;

	assign lbn      = LB_W'(req_q.sector >> PG_W);
	assign in_range = {23'd0, req_q.sector} < NUM_SECTORS;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		rd_addr = {old_q, idx_q[PG_W-1:0]};
	end

	always_ff @(posedge clk) begin
		flag_rd_q <= flag_mem[rd_addr];
		tag_rd_q  <= tag_mem[rd_addr];
		data_rd_q <= data_mem[rd_addr];
		if (wr_en) begin
			flag_mem[wr_addr] <= wr_flag;
			tag_mem[wr_addr]  <= wr_tag;
			data_mem[wr_addr] <= wr_word;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {spare_q, idx_q[PG_W-1:0]};
		wr_flag = flag_rd_q;
		wr_tag  = tag_rd_q;
		wr_word = data_rd_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_flag = 1'b0;
			end
			S_COPY_WR: begin
				wr_en = 1'b1;
				if (idx_q[PG_W-1:0] == hit_q) begin
					wr_flag = 1'b1;
					wr_tag  = req_q.sector;
					wr_word = req_q.wdata;
				end
			end
			S_ERASE: begin
				// drop the old block's flags one page at a time
				wr_en   = 1'b1;
				wr_addr = {old_q, idx_q[PG_W-1:0]};
				wr_flag = 1'b0;
			end
			S_SCAN_CMP: begin
				// append into the first free page once the scan finds no match
				if (idx_q[PG_W-1:0] == PG_W'(PAGES_PER_BLK - 1) && !hit_found_q &&
				    !(flag_rd_q && tag_rd_q == req_q.sector) &&
				    req_q.cmd == CMD_WRITE && (free_found_q || !flag_rd_q)) begin
					wr_en   = 1'b1;
					wr_addr = {old_q, free_found_q ? free_q : idx_q[PG_W-1:0]};
					wr_flag = 1'b1;
					wr_tag  = req_q.sector;
					wr_word = req_q.wdata;
				end
			end
			S_ALLOC: begin
				if (cand_q[PB_W-1:0] != spare_q && mk_q == (LB_W+1)'(LOG_BLOCKS) && !used_q) begin
					wr_en   = 1'b1;
					wr_addr = {cand_q[PB_W-1:0], {PG_W{1'b0}}};
					wr_flag = 1'b1;
					wr_tag  = req_q.sector;
					wr_word = req_q.wdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			map_valid_q  <= '0;
			spare_q      <= PB_W'(PHYS_BLOCKS - 1);
			out_valid    <= 1'b0;
			idx_q        <= '0;
			cand_q       <= '0;
			mk_q         <= '0;
			used_q       <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					// walk the whole store once, marking every page unwritten
					if (clr_q == ADDR_W'(NUM_PAGES - 1))
						state_q <= S_IDLE;
					clr_q <= clr_q + ADDR_W'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					idx_q        <= '0;
					hit_found_q  <= 1'b0;
					free_found_q <= 1'b0;
					cand_q       <= '0;
					mk_q         <= '0;
					used_q       <= 1'b0;
					out_data.rdata <= (req_q.cmd == CMD_WRITE) ? '0 : '1;
					if (!in_range) begin
						out_data.status <= ST_RANGE;
						state_q <= S_RESP;
					end else if (!map_valid_q[lbn]) begin
						out_data.status <= ST_ABSENT;
						state_q <= (req_q.cmd == CMD_WRITE) ? S_ALLOC : S_RESP;
					end else begin
						old_q   <= map_pbn_q[lbn];
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CMP;   // memory read latency
				S_SCAN_CMP: begin
					if (!hit_found_q && flag_rd_q && tag_rd_q == req_q.sector) begin
						hit_found_q <= 1'b1;
						hit_q       <= idx_q[PG_W-1:0];
						if (req_q.cmd == CMD_READ) begin
							out_data.rdata  <= data_rd_q;
							out_data.status <= ST_OK;
						end
					end
					if (!free_found_q && !flag_rd_q) begin
						free_found_q <= 1'b1;
						free_q       <= idx_q[PG_W-1:0];
					end
					if (idx_q[PG_W-1:0] == PG_W'(PAGES_PER_BLK - 1)) begin
						idx_q <= '0;
						if (req_q.cmd == CMD_READ) begin
							if (!hit_found_q && !(flag_rd_q && tag_rd_q == req_q.sector))
								out_data.status <= ST_ABSENT;
							state_q <= S_RESP;
						end else if (hit_found_q || (flag_rd_q && tag_rd_q == req_q.sector)) begin
							out_data.status <= ST_OK;
							state_q <= S_COPY_RD;
						end else if (wr_en) begin
							out_data.status <= ST_OK;
							state_q <= S_RESP;
						end else begin
							out_data.status <= ST_FULL;
							state_q <= S_RESP;
						end
					end else begin
						idx_q   <= idx_q + PG_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_ALLOC: begin
					// test one map entry per cycle against the candidate block
					if (cand_q == (PB_W+1)'(PHYS_BLOCKS)) begin
						out_data.status <= ST_FULL;
						state_q <= S_RESP;
					end else if (cand_q[PB_W-1:0] == spare_q ||
					             (mk_q == (LB_W+1)'(LOG_BLOCKS) && used_q)) begin
						cand_q <= cand_q + (PB_W+1)'(1);
						mk_q   <= '0;
						used_q <= 1'b0;
					end else if (mk_q == (LB_W+1)'(LOG_BLOCKS)) begin
						map_valid_q[lbn]    <= 1'b1;
						map_pbn_q[lbn]      <= cand_q[PB_W-1:0];
						out_data.status     <= ST_OK;
						state_q             <= S_RESP;
					end else begin
						if (map_valid_q[mk_q[LB_W-1:0]] &&
						    map_pbn_q[mk_q[LB_W-1:0]] == cand_q[PB_W-1:0])
							used_q <= 1'b1;
						mk_q <= mk_q + (LB_W+1)'(1);
					end
				end
				S_COPY_RD: state_q <= S_COPY_WR;
				S_COPY_WR: begin
					if (idx_q[PG_W-1:0] == PG_W'(PAGES_PER_BLK - 1)) begin
						idx_q   <= '0;
						state_q <= S_ERASE;
					end else begin
						idx_q   <= idx_q + PG_W'(1);
						state_q <= S_COPY_RD;
					end
				end
				S_ERASE: begin
					if (idx_q[PG_W-1:0] == PG_W'(PAGES_PER_BLK - 1)) begin
						map_pbn_q[lbn] <= spare_q;
						spare_q        <= old_q;
						state_q        <= S_RESP;
					end else begin
						idx_q <= idx_q + PG_W'(1);
					end
				end
				S_RESP: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/bmft_checker.sv */
module bmft_assertions (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input bmft_pkg::req_t  in_data,
	input logic            out_valid,
	input logic            out_stall,
	input bmft_pkg::rsp_t  out_data
);
	import bmft_pkg::*;

	// no new request while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken while result pending");

	// a held result does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// a full status answers zero data
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FULL) |-> out_data.rdata == '0)
		else $error("full status with data");

	// after a taken request the block is busy next cycle
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after accept");

endmodule

bind block_mapped_flash_translation_core bmft_assertions u_bmft_assertions (.*);

/* sim/bmft_checker.sv */
module bmft_checker
	import bmft_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   in_stall,
	input  req_t   in_data,
	input  logic   out_valid,
	input  logic   out_stall,
	input  rsp_t   out_data,
	output int     fail_count,
	output int     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic              map_ok [LOG_BLOCKS];
	logic [PB_W-1:0]   map_pbn [LOG_BLOCKS];
	logic [PB_W-1:0]   spare;
	logic              pg_wr [NUM_PAGES];
	logic [SEC_W-1:0]  pg_tag [NUM_PAGES];
	logic [DATA_W-1:0] pg_dat [NUM_PAGES];
	rsp_t              want_q [$];

	function automatic int find_page(int pbn, int sec);
		for (int i = 0; i < PAGES_PER_BLK; i++)
			if (pg_wr[pbn*PAGES_PER_BLK+i] && pg_tag[pbn*PAGES_PER_BLK+i] == sec)
				return i;
		return -1;
	endfunction

	function automatic logic [1:0] store_sector(int sec, logic [DATA_W-1:0] d);
		int lbn, old, hit, a, b;
		logic used;
		lbn = sec / PAGES_PER_BLK;
		if (!map_ok[lbn]) begin
			for (int p = 0; p < PHYS_BLOCKS; p++) begin
				used = 0;
				for (int k = 0; k < LOG_BLOCKS; k++)
					if (map_ok[k] && map_pbn[k] == p) used = 1;
				if (p != spare && !used) begin
					map_ok[lbn] = 1;
					map_pbn[lbn] = PB_W'(p);
					a = p * PAGES_PER_BLK;
					pg_wr[a] = 1; pg_tag[a] = SEC_W'(sec); pg_dat[a] = d;
					return ST_OK;
				end
			end
			return ST_FULL;
		end
		old = map_pbn[lbn];
		hit = find_page(old, sec);
		if (hit >= 0) begin
			for (int i = 0; i < PAGES_PER_BLK; i++) begin
				a = old * PAGES_PER_BLK + i;
				b = spare * PAGES_PER_BLK + i;
				if (i == hit) begin
					pg_wr[b] = 1; pg_tag[b] = SEC_W'(sec); pg_dat[b] = d;
				end else begin
					pg_wr[b] = pg_wr[a]; pg_tag[b] = pg_tag[a]; pg_dat[b] = pg_dat[a];
				end
				pg_wr[a] = 0;
			end
			map_pbn[lbn] = spare;
			spare = PB_W'(old);
			return ST_OK;
		end
		for (int i = 0; i < PAGES_PER_BLK; i++) begin
			a = old * PAGES_PER_BLK + i;
			if (!pg_wr[a]) begin
				pg_wr[a] = 1; pg_tag[a] = SEC_W'(sec); pg_dat[a] = d;
				return ST_OK;
			end
		end
		return ST_FULL;
	endfunction

	function automatic rsp_t translate(req_t r);
		rsp_t o;
		int lbn, hit;
		o.rdata = '1;
		o.status = ST_RANGE;
		if (r.cmd == CMD_WRITE) begin
			o.rdata = '0;
			if (r.sector < NUM_SECTORS) o.status = store_sector(r.sector, r.wdata);
		end else if (r.sector < NUM_SECTORS) begin
			lbn = r.sector / PAGES_PER_BLK;
			hit = map_ok[lbn] ? find_page(map_pbn[lbn], r.sector) : -1;
			o.status = ST_ABSENT;
			if (hit >= 0) begin
				o.rdata = pg_dat[map_pbn[lbn]*PAGES_PER_BLK + hit];
				o.status = ST_OK;
			end
		end
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch %s: got %h want %h at %t", what, got, exp, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		spare = PB_W'(PHYS_BLOCKS - 1);
		for (int k = 0; k < LOG_BLOCKS; k++) begin
			map_ok[k] = 0; map_pbn[k] = '0;
		end
		for (int i = 0; i < NUM_PAGES; i++) pg_wr[i] = 0;
	end

	assign pending = want_q.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					report("unexpected beat", out_data.rdata, 0);
				end else begin
					if (out_data.rdata !== want_q[0].rdata)
						report("rdata", out_data.rdata, want_q[0].rdata);
					if (out_data.status !== want_q[0].status)
						report("status", out_data.status, want_q[0].status);
					void'(want_q.pop_front());
				end
			end
			if (in_valid && !in_stall) want_q.push_back(translate(in_data));
		end
	end
endmodule

/* sim/tb.sv */
module tb;
	import bmft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	req_t in_data = '0;
	logic out_valid, in_stall;
	rsp_t out_data;
	int   fail_count, pending;
	int   send_idle, recv_idle;
	int   beats_sent;

	always #5 clk = ~clk;

	block_mapped_flash_translation_core uut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
	);

	bmft_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.fail_count, .pending
	);

	// Randomly stall the result side at each falling edge, per the current mix.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	// Offer one beat and hold it steady until taken; valid stays high after it and is
	// dropped only by the next call's idle gaps or by drain().
	task automatic send(logic c, int sec, logic [31:0] d);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{cmd: c, sector: sec[SEC_W-1:0], wdata: d};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (500) @(negedge clk);
	endtask

	// Mostly in-range sectors clustered in a few blocks so that rewrites,
	// appends and full blocks all happen; a little out-of-range noise.
	task automatic random_beats(int n);
		int sec, hot;
		for (int i = 0; i < n; i++) begin
			hot = $urandom_range(3);
			case ($urandom_range(9))
				0: sec = $urandom_range(511);
				1, 2: sec = $urandom_range(NUM_SECTORS - 1);
				default: sec = hot * PAGES_PER_BLK * 4 + $urandom_range(PAGES_PER_BLK - 1);
			endcase
			send(1'($urandom_range(1)), sec, $urandom());
		end
	endtask

	initial begin
		send_idle = 0;
		recv_idle = 0;
		beats_sent = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: empty reads (sector 0 on erased pages), range edges,
		// allocation, append, rewrite, payloads of all ones and zero.
		send(CMD_READ, 0, 0);
		send(CMD_READ, NUM_SECTORS - 1, 0);
		send(CMD_READ, NUM_SECTORS, 0);
		send(CMD_READ, 511, 0);
		send(CMD_WRITE, 511, 32'h1234);
		send(CMD_WRITE, NUM_SECTORS, 32'h1);
		send(CMD_WRITE, 0, 32'hFFFF_FFFF);
		send(CMD_READ, 0, 0);
		send(CMD_READ, 1, 0);
		send(CMD_WRITE, 1, 32'h0);
		send(CMD_WRITE, 0, 32'hFF00_0000);
		send(CMD_READ, 0, 0);
		send(CMD_READ, 1, 0);
		send(CMD_WRITE, NUM_SECTORS - 1, 32'hA5A5_5A5A);
		send(CMD_READ, NUM_SECTORS - 1, 32'hFFFF_FFFF);
		send(CMD_WRITE, 2 * PAGES_PER_BLK + 5, 32'h5555_AAAA);
		send(CMD_READ, 2 * PAGES_PER_BLK + 6, 0);
		// Pause until everything has come back.
		drain();

		send_idle = 32; recv_idle = 60;
		random_beats(600);
		send_idle = 60; recv_idle = 32;
		random_beats(600);
		drain();
		send_idle = 0; recv_idle = 0;
		random_beats(700);
		drain();

		$display("ran %0d beats: reads, appends, rewrites, allocation, full and out-of-range",
			beats_sent);
		$display("stall mixes 32/60, 60/32 and none; mismatches %0d", fail_count);
		if (fail_count == 0)
			$display("** block_mapped_flash_translation_core: PASSED **");
		else
			$display("** block_mapped_flash_translation_core: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** block_mapped_flash_translation_core: FAILED **");
		$finish;
	end
endmodule
